### rtl/core/deq_pkg.sv
`default_nettype none

package deq_pkg;

    // default number of stored values
    localparam int unsigned DEPTH_DEFAULT = 16;

    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned OP_W     = 2;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned OCC_W    = 5;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_REAR  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_REAR   = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // per-chain move command, shared by every cell of the chain
    typedef struct packed {
        logic shift_in;    // insert at cell 0, every cell takes its left neighbor
        logic shift_out;   // drop cell 0, every cell takes its right neighbor
        logic write_tail;  // write the value into the cell just past the last entry
    } t_cell_ctl;

endpackage

`default_nettype wire

### rtl/core/double_ended_queue_core.sv
// Double-ended queue of signed 32-bit values, DEPTH entries.
//
// Input channel (s_axis): tuser carries the operation (push front, push rear,
// pop front, pop rear), tdata carries the value to push (ignored for pops).
// Output channel (m_axis): one result transfer per input transfer, in order.
// tdata carries the popped value and the occupancy after the operation,
// tuser the status: done, pop on empty queue, push on full queue. A failed
// operation leaves the queue untouched and returns a zero value.
//
// Storage is two rows of cells holding the same entries in opposite order:
// the front row keeps the front entry in its cell 0, the rear row keeps the
// rear entry in its cell 0. A push at one end shifts that end's row by one
// cell and writes the other row just past its last entry; a pop shifts one
// row and trims the other through the count. Every operation is one move of
// the rows, so the block takes one transfer every cycle unless m_axis stalls.
//
// The result is registered and appears on m_axis in the cycle after the
// input transfer. When the receiver stalls, the result register holds and
// s_axis tready drops until it is taken. Reset empties the queue and the
// result register.
`default_nettype none

module double_ended_queue_core #(
    parameter int unsigned DEPTH = deq_pkg::DEPTH_DEFAULT
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input item
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [31:0] i_s_axis_tdata,   // [31:0] value
    input  wire logic [1:0]  i_s_axis_tuser,   // [1:0] op
    // result item
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [39:0]      o_m_axis_tdata,   // [31:0] popped_value, [36:32] occupancy
    output logic [1:0]       o_m_axis_tuser    // [1:0] status
);

    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned VW = deq_pkg::VALUE_W;

    // entry count
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;

    // result register
    logic              r_out_valid;
    logic              n_out_valid;
    logic [VW-1:0]     r_popped;
    logic [VW-1:0]     n_popped;
    deq_pkg::t_status  r_status;
    deq_pkg::t_status  n_status;
    logic [deq_pkg::OCC_W-1:0] r_occ;
    logic [deq_pkg::OCC_W-1:0] n_occ;

    logic              w_accept;
    deq_pkg::t_op      w_op;
    logic              w_full;
    logic              w_empty;
    logic              w_ok;
    logic [CW+deq_pkg::OCC_W-1:0] w_occ_ext;
    logic [VW-1:0]     w_front_head;
    logic [VW-1:0]     w_rear_head;
    deq_pkg::t_cell_ctl w_front_ctl;
    deq_pkg::t_cell_ctl w_rear_ctl;

    // take a new item whenever the result register is empty or being drained
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    assign w_op    = deq_pkg::t_op'(i_s_axis_tuser);
    assign w_full  = (r_count == CW'(DEPTH));
    assign w_empty = (r_count == '0);

    // decode the operation into row moves and the result
    always_comb begin
        w_ok        = 1'b0;
        n_popped    = '0;
        n_status    = deq_pkg::ST_DONE;
        w_front_ctl = '0;
        w_rear_ctl  = '0;
        unique case (w_op)
            deq_pkg::OP_PUSH_FRONT: begin
                w_ok                   = !w_full;
                n_status               = w_full ? deq_pkg::ST_FULL : deq_pkg::ST_DONE;
                w_front_ctl.shift_in   = w_accept && !w_full;
                w_rear_ctl.write_tail  = w_accept && !w_full;
            end
            deq_pkg::OP_PUSH_REAR: begin
                w_ok                   = !w_full;
                n_status               = w_full ? deq_pkg::ST_FULL : deq_pkg::ST_DONE;
                w_rear_ctl.shift_in    = w_accept && !w_full;
                w_front_ctl.write_tail = w_accept && !w_full;
            end
            deq_pkg::OP_POP_FRONT: begin
                w_ok                   = !w_empty;
                n_status               = w_empty ? deq_pkg::ST_EMPTY : deq_pkg::ST_DONE;
                n_popped               = w_empty ? '0 : w_front_head;
                w_front_ctl.shift_out  = w_accept && !w_empty;
            end
            deq_pkg::OP_POP_REAR: begin
                w_ok                   = !w_empty;
                n_status               = w_empty ? deq_pkg::ST_EMPTY : deq_pkg::ST_DONE;
                n_popped               = w_empty ? '0 : w_rear_head;
                w_rear_ctl.shift_out   = w_accept && !w_empty;
            end
            default: begin
                w_ok = 1'b0;
            end
        endcase
    end

    // advance the count on a successful operation
    always_comb begin
        n_count = r_count;
        if (w_accept && w_ok) begin
            if ((w_op == deq_pkg::OP_PUSH_FRONT) || (w_op == deq_pkg::OP_PUSH_REAR)) begin
                n_count = r_count + 1'b1;
            end else begin
                n_count = r_count - 1'b1;
            end
        end
    end

    // occupancy is reported masked to the field width
    assign w_occ_ext = {{deq_pkg::OCC_W{1'b0}}, n_count};
    assign n_occ     = w_occ_ext[deq_pkg::OCC_W-1:0];

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_accept) begin
            n_out_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // hold the result payload until the next accepted item
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_popped <= n_popped;
            r_status <= n_status;
            r_occ    <= n_occ;
        end
    end

    // front row: front entry in cell 0
    deq_chain #(
        .DEPTH (DEPTH),
        .CW    (CW)
    ) u_front (
        .i_clk   (i_clk),
        .i_ctl   (w_front_ctl),
        .i_count (r_count),
        .i_value (i_s_axis_tdata),
        .o_head  (w_front_head)
    );

    // rear row: rear entry in cell 0
    deq_chain #(
        .DEPTH (DEPTH),
        .CW    (CW)
    ) u_rear (
        .i_clk   (i_clk),
        .i_ctl   (w_rear_ctl),
        .i_count (r_count),
        .i_value (i_s_axis_tdata),
        .o_head  (w_rear_head)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b000, r_occ, r_popped};
    assign o_m_axis_tuser  = r_status;

    // ---------------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count beyond depth");

    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_full &&
         ((w_op == deq_pkg::OP_PUSH_FRONT) || (w_op == deq_pkg::OP_PUSH_REAR)))
        |=> (r_count == $past(r_count)) && (r_status == deq_pkg::ST_FULL))
        else $error("push on full queue changed the count");

    a_push_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_full &&
         ((w_op == deq_pkg::OP_PUSH_FRONT) || (w_op == deq_pkg::OP_PUSH_REAR)))
        |=> r_count == CW'($past(r_count) + 1'b1))
        else $error("push did not advance the count");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status != deq_pkg::ST_DONE)) |-> (r_popped == '0))
        else $error("failed operation returned a nonzero value");

endmodule

`default_nettype wire

### rtl/core/deq_cell.sv
`default_nettype none

module deq_cell #(
    parameter int unsigned DEPTH = deq_pkg::DEPTH_DEFAULT,
    parameter int unsigned IDX   = 0,
    parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
    input  wire logic                         i_clk,
    input  wire deq_pkg::t_cell_ctl           i_ctl,
    input  wire logic [CW-1:0]                i_count,
    input  wire logic [deq_pkg::VALUE_W-1:0]  i_value,
    input  wire logic [deq_pkg::VALUE_W-1:0]  i_left,
    input  wire logic [deq_pkg::VALUE_W-1:0]  i_right,
    output logic      [deq_pkg::VALUE_W-1:0]  o_data
);

    logic [deq_pkg::VALUE_W-1:0] r_data;
    logic [deq_pkg::VALUE_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_ctl.shift_in) begin
            n_data = i_left;
        end else if (i_ctl.shift_out) begin
            n_data = i_right;
        end else if (i_ctl.write_tail && (i_count == CW'(IDX))) begin
            n_data = i_value;
        end
    end

    // payload only, no reset
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

### rtl/core/deq_chain.sv
`default_nettype none

module deq_chain #(
    parameter int unsigned DEPTH = deq_pkg::DEPTH_DEFAULT,
    parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
    input  wire logic                         i_clk,
    input  wire deq_pkg::t_cell_ctl           i_ctl,
    input  wire logic [CW-1:0]                i_count,
    input  wire logic [deq_pkg::VALUE_W-1:0]  i_value,
    output logic      [deq_pkg::VALUE_W-1:0]  o_head
);

    logic [deq_pkg::VALUE_W-1:0] w_cell [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [deq_pkg::VALUE_W-1:0] w_left;
        logic [deq_pkg::VALUE_W-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = i_value;
        end else begin : g_mid_l
            assign w_left = w_cell[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_cell[g+1];
        end

        deq_cell #(
            .DEPTH (DEPTH),
            .IDX   (g),
            .CW    (CW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (i_ctl),
            .i_count (i_count),
            .i_value (i_value),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_cell[g])
        );
    end

    assign o_head = w_cell[0];

endmodule

`default_nettype wire
